FILE: sv/rrt_pkg.sv
// Package for the reserved region table: default sizes, status codes, item and result
// structures shared by the sequencer and the top level.
// Depends on nothing.
`default_nettype none
package rrt_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ADDR_BITS_DEF = 48;
    localparam int FIELD_W       = 48;
    localparam int INDEX_W       = 4;
    localparam int S_DATA_W      = 104;
    localparam int M_DATA_W      = 104;

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_REVERSED  = 2'd2,
        STATUS_BAD_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic                 mode;
        logic [FIELD_W-1:0]   range_start;
        logic [FIELD_W-1:0]   range_end;
        logic [INDEX_W-1:0]   entry_index;
    } rrt_req_t;

    typedef struct packed {
        status_t              status;
        logic [FIELD_W-1:0]   entry_start;
        logic [FIELD_W-1:0]   entry_end;
        logic [INDEX_W-1:0]   region_count;
    } rrt_resp_t;

endpackage
`default_nettype wire

FILE: sv/reserved_region_table_insert.sv
// Reserved region table: sorted list of half-open address ranges with coalescing insert.
// A read item waits for its RAM read and then its response state; a reserve item runs a scan
// pass and, where needed, an insert-shift or merge pass over the entry RAM. Items are handled
// one at a time: the next item is taken once a result has moved on to the output register,
// which may still be waiting for the sink.
// Reset clears the entry count and the output valid flag; table entries are undefined until written.
`default_nettype none
module reserved_region_table_insert #(
    parameter int DEPTH     = rrt_pkg::DEPTH_DEF,
    parameter int ADDR_BITS = rrt_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // range_start, range_end, entry_index, zero padding
    input  wire logic [rrt_pkg::S_DATA_W-1:0] s_tdata,
    // mode
    input  wire logic                         s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // status, entry_start, entry_end, region_count, zero padding
    output logic      [rrt_pkg::M_DATA_W-1:0] m_tdata
);
    import rrt_pkg::*;

    localparam int PAD_W = M_DATA_W - $bits(rrt_resp_t);

    rrt_req_t              req;
    rrt_resp_t             resp;
    logic                  in_valid;
    logic                  idle;
    logic                  out_free;
    logic                  resp_valid;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    always_comb begin
        req.mode        = s_tuser;
        req.range_start = s_tdata[FIELD_W-1:0];
        req.range_end   = s_tdata[2*FIELD_W-1:FIELD_W];
        req.entry_index = s_tdata[2*FIELD_W+INDEX_W-1:2*FIELD_W];
    end

    assign s_tready = idle;
    assign in_valid = s_tvalid && idle;
    assign out_free = !m_valid_reg || m_tready;

    rrt_ctrl #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid),
        .in_req     (req),
        .idle       (idle),
        .out_free   (out_free),
        .resp_valid (resp_valid),
        .resp       (resp)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (resp_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = {{PAD_W{1'b0}}, resp.region_count, resp.entry_end,
                            resp.entry_start, resp.status};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

FILE: sv/rrt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module rrt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: sv/rrt_ctrl.sv
// Sequencer for the reserved region table: scan, insert-shift and merge passes over the
// entry RAM, one entry per cycle. Depends on rrt_pkg and rrt_ram.
`default_nettype none
module rrt_ctrl #(
    parameter int DEPTH     = rrt_pkg::DEPTH_DEF,
    parameter int ADDR_BITS = rrt_pkg::ADDR_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire rrt_pkg::rrt_req_t in_req,
    output logic                   idle,
    input  wire logic              out_free,
    output logic                   resp_valid,
    output rrt_pkg::rrt_resp_t     resp
);
    import rrt_pkg::*;

    localparam int AW       = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int CW       = $clog2(DEPTH);
    localparam int CMPW     = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int MEM_DEPTH = 1 << CW;

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b0000000001,
        ST_READ_WAIT  = 10'b0000000010,
        ST_SCAN       = 10'b0000000100,
        ST_INSERT     = 10'b0000001000,
        ST_JOIN_START = 10'b0000010000,
        ST_JOIN_FIRST = 10'b0000100000,
        ST_JOIN_LOOP  = 10'b0001000000,
        ST_JOIN_END   = 10'b0010000000,
        ST_RESP       = 10'b0100000000,
        ST_SPARE      = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   s_reg, s_next;
    logic [AW-1:0]   e_reg, e_next;
    logic [AW-1:0]   prev_s_reg, prev_s_next;
    logic [AW-1:0]   prev_e_reg, prev_e_next;
    logic [2*AW-1:0] carry_reg, carry_next;
    status_t         res_status_reg, res_status_next;
    logic [AW-1:0]   res_start_reg, res_start_next;
    logic [AW-1:0]   res_end_reg, res_end_next;

    logic            wr_en;
    logic [CW-1:0]   wr_addr;
    logic [2*AW-1:0] wr_data;
    logic [CW-1:0]   rd_addr;
    logic [2*AW-1:0] rd_data;
    logic [AW-1:0]   rd_s;
    logic [AW-1:0]   rd_e;
    logic [AW-1:0]   in_s;
    logic [AW-1:0]   in_e;
    logic            table_full;
    logic            scan_last;
    logic            join_last;

    rrt_ram #(
        .WIDTH (2 * AW),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_s       = rd_data[AW-1:0];
    assign rd_e       = rd_data[2*AW-1:AW];
    assign in_s       = in_req.range_start[AW-1:0];
    assign in_e       = in_req.range_end[AW-1:0];
    assign table_full = (count_reg == CW'(DEPTH - 1));
    assign scan_last  = (CW'(idx_reg + 1'b1) == count_reg);
    assign join_last  = (idx_reg == CW'(count_reg - 1'b1));
    assign idle       = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        prev_s_next     = prev_s_reg;
        prev_e_next     = prev_e_reg;
        carry_next      = carry_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {e_reg, s_reg};
        rd_addr         = CW'(idx_reg + 1'b1);
        resp_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = (in_req.mode == MODE_READ) ? CW'(in_req.entry_index) : '0;
                if (in_valid) begin
                    s_next          = in_s;
                    e_next          = in_e;
                    res_status_next = STATUS_OK;
                    res_start_next  = '0;
                    res_end_next    = '0;
                    idx_next        = '0;
                    if (in_req.mode == MODE_READ) begin
                        if (CMPW'(in_req.entry_index) < CMPW'(count_reg)) begin
                            state_next = ST_READ_WAIT;
                        end else begin
                            res_status_next = STATUS_BAD_INDEX;
                            state_next      = ST_RESP;
                        end
                    end else if (in_s == in_e) begin
                        state_next = ST_RESP;
                    end else if (in_s > in_e) begin
                        res_status_next = STATUS_REVERSED;
                        state_next      = ST_RESP;
                    end else if (count_reg == '0) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {in_e, in_s};
                        count_next = CW'(1);
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_READ_WAIT: begin
                res_start_next = rd_s;
                res_end_next   = rd_e;
                state_next     = ST_RESP;
            end
            ST_SCAN: begin
                if (rd_s == e_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = {rd_e, s_reg};
                    state_next = ST_JOIN_START;
                end else if (rd_e == s_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = {e_reg, rd_s};
                    state_next = ST_JOIN_START;
                end else if (rd_s > e_reg) begin
                    if (table_full) begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_RESP;
                    end else begin
                        wr_en      = 1'b1;
                        carry_next = rd_data;
                        idx_next   = CW'(idx_reg + 1'b1);
                        state_next = ST_INSERT;
                    end
                end else if (scan_last) begin
                    if (table_full) begin
                        res_status_next = STATUS_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg;
                        count_next = CW'(count_reg + 1'b1);
                    end
                    state_next = ST_RESP;
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end
            ST_INSERT: begin
                wr_en      = 1'b1;
                wr_data    = carry_reg;
                carry_next = rd_data;
                if (idx_reg == count_reg) begin
                    count_next = CW'(count_reg + 1'b1);
                    state_next = ST_RESP;
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end
            ST_JOIN_START: begin
                rd_addr    = '0;
                state_next = ST_JOIN_FIRST;
            end
            ST_JOIN_FIRST: begin
                rd_addr     = CW'(1);
                prev_s_next = rd_s;
                prev_e_next = rd_e;
                wptr_next   = '0;
                idx_next    = CW'(1);
                state_next  = (count_reg == CW'(1)) ? ST_JOIN_END : ST_JOIN_LOOP;
            end
            ST_JOIN_LOOP: begin
                if (prev_e_reg == rd_s) begin
                    prev_e_next = rd_e;
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = wptr_reg;
                    wr_data     = {prev_e_reg, prev_s_reg};
                    wptr_next   = CW'(wptr_reg + 1'b1);
                    prev_s_next = rd_s;
                    prev_e_next = rd_e;
                end
                if (join_last) begin
                    state_next = ST_JOIN_END;
                end else begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
            end
            ST_JOIN_END: begin
                wr_en      = 1'b1;
                wr_addr    = wptr_reg;
                wr_data    = {prev_e_reg, prev_s_reg};
                count_next = CW'(wptr_reg + 1'b1);
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    resp_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        resp.status       = res_status_reg;
        resp.entry_start  = FIELD_W'(res_start_reg);
        resp.entry_end    = FIELD_W'(res_end_reg);
        resp.region_count = INDEX_W'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg        <= idx_next;
        wptr_reg       <= wptr_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        prev_s_reg     <= prev_s_next;
        prev_e_reg     <= prev_e_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
    end

endmodule
`default_nettype wire
